@@ sv/rotating_fnv_stream_hash_64_assert.svh @@
// Assertion macros shared by the checker files of the rotating FNV stream hash.
`ifndef ROTATING_FNV_STREAM_HASH_64_ASSERT_SVH
`define ROTATING_FNV_STREAM_HASH_64_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RFH_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rfh: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define RFH_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rfh: next-cycle check failed");

`endif

@@ sv/rfh_pkg.sv @@
// Package: opcodes, hash constants and sequencer states of the stream hash.
`timescale 1ns / 1ps

package rfh_pkg;

   localparam int HASH_W = 64;

   // Item opcodes
   localparam logic OP_ABSORB = 1'b0;
   localparam logic OP_FINISH = 1'b1;

   // FNV-1a 64 constants; the prime is 2^40 + 0x1B3
   localparam logic [HASH_W-1:0] OFFSET_BASIS   = 64'hCBF2_9CE4_8422_2325;
   localparam logic [8:0]        FNV_PRIME_LO   = 9'h1B3;
   localparam int                FNV_PRIME_SHIFT = 40;
   localparam int                ROT_LEFT       = 5;

   // splitmix64 finalizer constants
   localparam logic [HASH_W-1:0] FIN_MUL_A = 64'hBF58_476D_1CE4_E5B9;
   localparam logic [HASH_W-1:0] FIN_MUL_B = 64'h94D0_49BB_1331_11EB;
   localparam int                FIN_SH_0  = 30;
   localparam int                FIN_SH_1  = 27;
   localparam int                FIN_SH_2  = 31;

   // Sequencer states
   typedef enum logic [1:0] {
      S_IDLE,
      S_MUL_A,
      S_MUL_B,
      S_EMIT
   } state_type;

endpackage

@@ sv/rfh_if.sv @@
// Interfaces: request channel (opcode and byte) and response channel (digest).
`timescale 1ns / 1ps

interface rfh_req_if;
   logic       valid;
   logic       ready;
   logic       operation;
   logic [7:0] data_byte;

   modport source (output valid, output operation, output data_byte, input ready);
   modport sink   (input valid, input operation, input data_byte, output ready);
endinterface

interface rfh_rsp_if;
   logic                      valid;
   logic                      ready;
   logic [rfh_pkg::HASH_W-1:0] digest;
   logic                      length_overflow;

   modport source (output valid, output digest, output length_overflow, input ready);
   modport sink   (input valid, input digest, input length_overflow, output ready);
endinterface

@@ sv/rfh_mul64.sv @@
// Iterative 64x64 (low half) multiplier built on one 32x32 multiplier.
`timescale 1ns / 1ps

module rfh_mul64 (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [rfh_pkg::HASH_W-1:0] op_a,
   input  logic [rfh_pkg::HASH_W-1:0] op_b,
   output logic                       done,
   output logic [rfh_pkg::HASH_W-1:0] product
);

   localparam int HALF_W = rfh_pkg::HASH_W / 2;

   // Partial product steps: lo*lo, hi*lo, lo*hi (hi*hi falls off the top)
   localparam logic [1:0] STEP_LL = 2'd0;
   localparam logic [1:0] STEP_HL = 2'd1;
   localparam logic [1:0] STEP_LH = 2'd2;

   logic                       busy_ff, busy_in;
   logic                       done_ff, done_in;
   logic [1:0]                 step_ff, step_in;
   logic [rfh_pkg::HASH_W-1:0] acc_ff, acc_in;
   logic [HALF_W-1:0]          mul_x, mul_y;
   logic [rfh_pkg::HASH_W-1:0] part;

   // Pick the operand halves for this step
   always_comb begin
      unique case (step_ff)
         STEP_LL: begin
            mul_x = op_a[HALF_W-1:0];
            mul_y = op_b[HALF_W-1:0];
         end
         STEP_HL: begin
            mul_x = op_a[rfh_pkg::HASH_W-1:HALF_W];
            mul_y = op_b[HALF_W-1:0];
         end
         STEP_LH: begin
            mul_x = op_a[HALF_W-1:0];
            mul_y = op_b[rfh_pkg::HASH_W-1:HALF_W];
         end
         default: begin
            mul_x = op_a[HALF_W-1:0];
            mul_y = op_b[HALF_W-1:0];
         end
      endcase
   end

   // The shared 32x32 multiplier
   assign part = rfh_pkg::HASH_W'(mul_x) * rfh_pkg::HASH_W'(mul_y);

   // Accumulate partial products, advance the step counter
   always_comb begin
      acc_in  = acc_ff;
      busy_in = busy_ff;
      step_in = step_ff;
      done_in = 1'b0;
      if (start) begin
         busy_in = 1'b1;
         step_in = STEP_LL;
      end else if (busy_ff) begin
         if (step_ff == STEP_LL) begin
            acc_in = part;
         end else begin
            acc_in = acc_ff + {part[HALF_W-1:0], {HALF_W{1'b0}}};
         end
         step_in = step_ff + 2'd1;
         if (step_ff == STEP_LH) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= STEP_LL;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      acc_ff <= acc_in;
   end

   assign done    = done_ff;
   assign product = acc_ff;

endmodule

@@ sv/rotating_fnv_stream_hash_64.sv @@
// Top level: rotating FNV-1a 64 stream hash with splitmix64 finalizer.
//
//   channel  | dir | handshake      | payload
//   req_ch   | in  | valid / ready  | operation, data_byte
//   rsp_ch   | out | valid / ready  | digest, length_overflow
//   csr      | in  | csr_wr_en      | csr_wr_data (seed)
//
// An absorb item leaves the sequencer in S_IDLE; ready stays high across a run of bytes.
// A finish item holds ready low while the finalizer runs: two finalizer
// multiplies on the shared 32x32 multiplier, then S_EMIT loads the
// response register. A stalled response lengthens only the finish.
// Synchronous reset clears the seed, the message state and the response valid.
`timescale 1ns / 1ps

module rotating_fnv_stream_hash_64 #(
   parameter int LENGTH_BITS = 32
) (
   input  logic                       clock,
   input  logic                       reset,
   rfh_req_if.sink                    req_ch,
   rfh_rsp_if.source                  rsp_ch,
   input  logic                       csr_wr_en,
   input  logic [rfh_pkg::HASH_W-1:0] csr_wr_data
);

   localparam logic [LENGTH_BITS-1:0] COUNT_MAX = '1;

   rfh_pkg::state_type          state_ff, state_in;
   logic [rfh_pkg::HASH_W-1:0]  seed_ff;
   logic [rfh_pkg::HASH_W-1:0]  hash_ff, hash_in;
   logic [LENGTH_BITS-1:0]      count_ff, count_in;
   logic                        open_ff, open_in;
   logic                        sat_ff, sat_in;
   logic [rfh_pkg::HASH_W-1:0]  work_ff, work_in;
   logic                        flag_ff, flag_in;
   logic [rfh_pkg::HASH_W-1:0]  digest_ff;
   logic                        ovf_ff;
   logic                        rsp_valid_ff, rsp_valid_in;

   logic                        req_fire;
   logic                        fire_absorb, fire_finish;
   logic                        rsp_load;
   logic                        mul_start, mul_done;
   logic [rfh_pkg::HASH_W-1:0]  mul_coef, mul_prod;

   logic [rfh_pkg::HASH_W-1:0]  base_hash;
   logic [LENGTH_BITS-1:0]      base_count;
   logic                        base_sat;
   logic [rfh_pkg::HASH_W-1:0]  mix_x, mix_h, fold_t;

   assign req_fire    = req_ch.valid & req_ch.ready;
   assign fire_absorb = req_fire & (req_ch.operation == rfh_pkg::OP_ABSORB);
   assign fire_finish = req_fire & (req_ch.operation == rfh_pkg::OP_FINISH);

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         rfh_pkg::S_IDLE:  if (fire_finish) state_in = rfh_pkg::S_MUL_A;
         rfh_pkg::S_MUL_A: if (mul_done) state_in = rfh_pkg::S_MUL_B;
         rfh_pkg::S_MUL_B: if (mul_done) state_in = rfh_pkg::S_EMIT;
         rfh_pkg::S_EMIT:  if (!rsp_valid_ff || rsp_ch.ready) state_in = rfh_pkg::S_IDLE;
         default:          state_in = rfh_pkg::S_IDLE;
      endcase
   end

   // Sequencer outputs
   always_comb begin
      req_ch.ready = 1'b0;
      mul_start    = 1'b0;
      mul_coef     = rfh_pkg::FIN_MUL_A;
      rsp_load     = 1'b0;
      unique case (state_ff)
         rfh_pkg::S_IDLE: begin
            req_ch.ready = 1'b1;
            mul_start    = fire_finish;
         end
         rfh_pkg::S_MUL_A: begin
            mul_start = mul_done;
         end
         rfh_pkg::S_MUL_B: begin
            mul_coef = rfh_pkg::FIN_MUL_B;
         end
         rfh_pkg::S_EMIT: begin
            rsp_load = !rsp_valid_ff || rsp_ch.ready;
         end
         default: begin
            req_ch.ready = 1'b0;
         end
      endcase
   end

   // Message start view: a closed message reads as freshly opened
   always_comb begin
      if (open_ff) begin
         base_hash  = hash_ff;
         base_count = count_ff;
         base_sat   = sat_ff;
      end else begin
         base_hash  = seed_ff ^ rfh_pkg::OFFSET_BASIS;
         base_count = '0;
         base_sat   = 1'b0;
      end
   end

   // Byte step: xor, multiply by 2^40 + 0x1B3, rotate left
   assign mix_x  = base_hash ^ rfh_pkg::HASH_W'(req_ch.data_byte);
   assign mix_h  = (mix_x << rfh_pkg::FNV_PRIME_SHIFT)
                 + mix_x * rfh_pkg::HASH_W'(rfh_pkg::FNV_PRIME_LO);
   assign fold_t = base_hash ^ rfh_pkg::HASH_W'(base_count);

   // Message state and finalizer work register
   always_comb begin
      hash_in  = hash_ff;
      count_in = count_ff;
      open_in  = open_ff;
      sat_in   = sat_ff;
      work_in  = work_ff;
      flag_in  = flag_ff;
      if (fire_absorb) begin
         hash_in = {mix_h[rfh_pkg::HASH_W-rfh_pkg::ROT_LEFT-1:0],
                    mix_h[rfh_pkg::HASH_W-1:rfh_pkg::HASH_W-rfh_pkg::ROT_LEFT]};
         open_in = 1'b1;
         if (base_count == COUNT_MAX) begin
            count_in = base_count;
            sat_in   = 1'b1;
         end else begin
            count_in = base_count + LENGTH_BITS'(1);
            sat_in   = base_sat;
         end
      end else if (fire_finish) begin
         work_in = fold_t ^ (fold_t >> rfh_pkg::FIN_SH_0);
         flag_in = base_sat;
         open_in = 1'b0;
      end else if (mul_done && state_ff == rfh_pkg::S_MUL_A) begin
         work_in = mul_prod ^ (mul_prod >> rfh_pkg::FIN_SH_1);
      end else if (mul_done && state_ff == rfh_pkg::S_MUL_B) begin
         work_in = mul_prod ^ (mul_prod >> rfh_pkg::FIN_SH_2);
      end
   end

   // Response register: hold until taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rfh_pkg::S_IDLE;
         seed_ff      <= '0;
         hash_ff      <= '0;
         count_ff     <= '0;
         open_ff      <= 1'b0;
         sat_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         hash_ff      <= hash_in;
         count_ff     <= count_in;
         open_ff      <= open_in;
         sat_ff       <= sat_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            seed_ff <= csr_wr_data;
         end
      end
      work_ff <= work_in;
      flag_ff <= flag_in;
      if (rsp_load) begin
         digest_ff <= work_ff;
         ovf_ff    <= flag_ff;
      end
   end

   rfh_mul64 u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .op_a    (work_ff),
      .op_b    (mul_coef),
      .done    (mul_done),
      .product (mul_prod)
   );

   assign rsp_ch.valid           = rsp_valid_ff;
   assign rsp_ch.digest          = digest_ff;
   assign rsp_ch.length_overflow = ovf_ff;

endmodule

@@ sv/rfh_checker.sv @@
// Port-level checker for the stream hash, bound to the top level.
`timescale 1ns / 1ps
`include "rotating_fnv_stream_hash_64_assert.svh"

module rfh_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_ready,
   input logic                       req_operation,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic [rfh_pkg::HASH_W-1:0] rsp_digest,
   input logic                       rsp_length_overflow
);

   logic req_fire;

   assign req_fire = req_valid & req_ready;

   // A stalled response keeps its valid and payload
   `RFH_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_digest) && $stable(rsp_length_overflow))

   // A finish item closes the input while the finalizer runs
   `RFH_ASSERT_NEXT(a_finish_busy, clock, reset, req_fire && req_operation == rfh_pkg::OP_FINISH, !req_ready)

   // An absorb item never produces a response
   `RFH_ASSERT_NEXT(a_absorb_silent, clock, reset, req_fire && req_operation == rfh_pkg::OP_ABSORB && !rsp_valid, !rsp_valid)

   // Leaving reset: ready for input, nothing to deliver
   `RFH_ASSERT_SAME(a_after_reset, clock, 1'b0, $past(reset), req_ready && !rsp_valid)

endmodule

bind rotating_fnv_stream_hash_64 rfh_checker u_rfh_checker (
   .clock               (clock),
   .reset               (reset),
   .req_valid           (req_ch.valid),
   .req_ready           (req_ch.ready),
   .req_operation       (req_ch.operation),
   .rsp_valid           (rsp_ch.valid),
   .rsp_ready           (rsp_ch.ready),
   .rsp_digest          (rsp_ch.digest),
   .rsp_length_overflow (rsp_ch.length_overflow)
);

@@ tb/rotating_fnv_stream_hash_64_tb.sv @@
// Self-checking testbench for the rotating FNV-1a 64 stream hash with splitmix64 finalizer.
`timescale 1ns / 1ps

module rotating_fnv_stream_hash_64_tb;

   // Byte counter width of the block under test
   localparam int LEN_BITS = 32;
   localparam logic [63:0] COUNT_MAX = (64'd1 << LEN_BITS) - 64'd1;

   localparam logic [63:0] BASIS     = 64'hCBF2_9CE4_8422_2325;
   localparam logic [63:0] FNV_PRIME = 64'h0000_0100_0000_01B3;
   localparam logic [63:0] MIX_A     = 64'hBF58_476D_1CE4_E5B9;
   localparam logic [63:0] MIX_B     = 64'h94D0_49BB_1331_11EB;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_PAUSE    = 12;
   localparam int END_PAUSE      = 20;

   typedef struct packed {
      logic       op;
      logic [7:0] data;
   } stream_item_type;

   typedef struct packed {
      logic [63:0] digest;
      logic        overflow;
   } digest_type;

   logic clock = 1'b0;
   logic reset;
   logic csr_wr_en;
   logic [rfh_pkg::HASH_W-1:0] csr_wr_data;

   rfh_req_if req_if ();
   rfh_rsp_if rsp_if ();

   rotating_fnv_stream_hash_64 #(
      .LENGTH_BITS(LEN_BITS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_ch(req_if),
      .rsp_ch(rsp_if),
      .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   always #6 clock = ~clock;

   // Items waiting to be driven and digests waiting to come out
   stream_item_type stream_q[$];
   digest_type      expected_digests[$];

   // Hash model state
   logic [63:0] seed_model = '0;
   logic [63:0] hash_model = '0;
   logic [63:0] count_model = '0;
   logic        open_model = 1'b0;
   logic        sat_model = 1'b0;

   bit req_taken = 1'b0;
   bit no_idle = 1'b0;
   int gap_left = 0;
   int stall_left = 0;
   int idle_cycles = 0;
   int mismatch_count = 0;
   int digests_checked = 0;
   int overflow_digests = 0;
   int bytes_hashed = 0;
   int seed_writes = 0;

   // Gap length: mostly none or short, a few long
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (no_idle || r < 55) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [7:0] pick_byte();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return 8'h00;
      if (r == 1) return 8'hFF;
      return 8'($urandom_range(0, 255));
   endfunction

   function automatic logic [63:0] splitmix_finish(logic [63:0] v);
      v = v ^ (v >> 30);
      v = v * MIX_A;
      v = v ^ (v >> 27);
      v = v * MIX_B;
      return v ^ (v >> 31);
   endfunction

   // Advance the hash model by one accepted item
   task automatic hash_model_step(input logic op, input logic [7:0] data);
      logic [63:0] h;
      digest_type  want;
      if (!open_model) begin
         hash_model = seed_model ^ BASIS;
         count_model = '0;
         sat_model = 1'b0;
         open_model = 1'b1;
      end
      if (op == rfh_pkg::OP_ABSORB) begin
         h = (hash_model ^ {56'd0, data}) * FNV_PRIME;
         hash_model = {h[58:0], h[63:59]};
         if (count_model >= COUNT_MAX) sat_model = 1'b1;
         else count_model = count_model + 64'd1;
      end else begin
         want.digest = splitmix_finish(hash_model ^ count_model);
         want.overflow = sat_model;
         expected_digests.insert(expected_digests.size(), want);
         open_model = 1'b0;
      end
   endtask

   task automatic report_mismatch(input string detail);
      $display("MISMATCH at %0t ns: %s", $time, detail);
      mismatch_count++;
   endtask

   task automatic queue_item(input logic op, input logic [7:0] data);
      stream_item_type item;
      item.op = op;
      item.data = data;
      stream_q.insert(stream_q.size(), item);
   endtask

   // Queue a message of len random bytes, closed by a finish if asked
   task automatic queue_message(input int len, input bit close);
      for (int i = 0; i < len; i++) queue_item(rfh_pkg::OP_ABSORB, pick_byte());
      if (close) queue_item(rfh_pkg::OP_FINISH, pick_byte());
   endtask

   // Queue closed messages of random length until the item budget is met, then an open one if asked
   task automatic fill_random(input int budget, input bit leave_open);
      int len;
      int queued;
      int r;
      queued = 0;
      while (queued < budget) begin
         r = $urandom_range(0, 99);
         if (r < 3) len = $urandom_range(250, 300);
         else if (r < 12) len = 0;
         else if (r < 80) len = $urandom_range(1, 8);
         else len = $urandom_range(9, 40);
         queue_message(len, 1'b1);
         queued += len + 1;
      end
      if (leave_open) queue_message($urandom_range(1, 5), 1'b0);
   endtask

   // Hold until every item is taken and every digest has come out
   task automatic drain();
      while (stream_q.size() != 0 || req_if.valid || expected_digests.size() != 0)
         @(posedge clock);
   endtask

   // Wait for the block to drain and settle, then write the seed while it is idle
   task automatic write_seed(input logic [63:0] value);
      drain();
      repeat (DRAIN_PAUSE) @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      seed_writes++;
   endtask

   // Drive request items with random gaps
   always @(negedge clock) begin
      stream_item_type next_item;
      if (reset) begin
         req_if.valid <= 1'b0;
      end else if (!req_if.valid || req_taken) begin
         if (gap_left > 0) begin
            req_if.valid <= 1'b0;
            gap_left--;
         end else if (stream_q.size() > 0) begin
            next_item = stream_q.pop_front();
            req_if.operation <= next_item.op;
            req_if.data_byte <= next_item.data;
            req_if.valid <= 1'b1;
            gap_left = pick_gap();
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // Stall the response channel at random
   always @(negedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else if (stall_left > 0) begin
         rsp_if.ready <= 1'b0;
         stall_left--;
      end else begin
         rsp_if.ready <= 1'b1;
         if ($urandom_range(0, 2) == 0) stall_left = pick_gap();
      end
   end

   // Track seed writes, predict accepted items, check accepted digests
   always @(posedge clock) begin
      digest_type want;
      if (!reset) begin
         if (csr_wr_en) seed_model = csr_wr_data;
         if (req_if.valid && req_if.ready) begin
            hash_model_step(req_if.operation, req_if.data_byte);
            if (req_if.operation == rfh_pkg::OP_ABSORB) bytes_hashed++;
         end
         if (rsp_if.valid && rsp_if.ready) begin
            if (expected_digests.size() == 0) begin
               report_mismatch($sformatf("unexpected digest %h", rsp_if.digest));
            end else begin
               want = expected_digests.pop_front();
               digests_checked++;
               if (want.overflow) overflow_digests++;
               if (rsp_if.digest !== want.digest)
                  report_mismatch($sformatf("digest %h, want %h", rsp_if.digest, want.digest));
               if (rsp_if.length_overflow !== want.overflow)
                  report_mismatch($sformatf("length_overflow %b, want %b",
                                            rsp_if.length_overflow, want.overflow));
            end
         end
      end
      req_taken <= req_if.valid && req_if.ready;
   end

   // Abort when nothing moves for too long
   always @(posedge clock) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) || csr_wr_en)
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Watchdog: no handshake for %0d cycles at %0t ns", idle_cycles, $time);
         $display("Verification failed");
         $finish;
      end
   end

   initial begin
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      req_if.valid = 1'b0;
      req_if.operation = rfh_pkg::OP_ABSORB;
      req_if.data_byte = '0;
      rsp_if.ready = 1'b0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset seed: empty messages, extreme bytes, finish with junk byte
      queue_item(rfh_pkg::OP_FINISH, 8'hFF);
      queue_item(rfh_pkg::OP_ABSORB, 8'h00);
      queue_item(rfh_pkg::OP_FINISH, 8'h00);
      queue_item(rfh_pkg::OP_ABSORB, 8'hFF);
      queue_item(rfh_pkg::OP_ABSORB, 8'h80);
      queue_item(rfh_pkg::OP_ABSORB, 8'h01);
      queue_item(rfh_pkg::OP_FINISH, 8'hA5);
      queue_item(rfh_pkg::OP_FINISH, 8'h00);
      queue_item(rfh_pkg::OP_FINISH, 8'hFF);

      // All-ones seed, then leave a message open
      write_seed('1);
      queue_item(rfh_pkg::OP_FINISH, 8'h00);
      queue_item(rfh_pkg::OP_ABSORB, 8'h5A);
      queue_item(rfh_pkg::OP_ABSORB, 8'hA5);
      queue_item(rfh_pkg::OP_FINISH, 8'hFF);
      queue_item(rfh_pkg::OP_ABSORB, 8'h00);
      queue_item(rfh_pkg::OP_ABSORB, 8'hFF);

      // Change the seed mid-message: it applies from the next message
      write_seed('0);
      queue_item(rfh_pkg::OP_ABSORB, 8'h3C);
      queue_item(rfh_pkg::OP_FINISH, 8'h7E);
      queue_item(rfh_pkg::OP_FINISH, 8'h81);

      // Random phases, each with its own seed and idling style
      for (int p = 0; p < 6; p++) begin
         if (p == 2) write_seed('1);
         else if (p == 4) write_seed('0);
         else write_seed({$urandom, $urandom});
         no_idle = (p % 3 == 1);
         fill_random(190, p != 5);
      end

      drain();
      repeat (END_PAUSE) @(negedge clock);
      if (expected_digests.size() != 0)
         report_mismatch($sformatf("%0d digests never arrived", expected_digests.size()));

      $display("Covered %0d bytes in %0d digests, %0d with length overflow, over %0d seeds",
               bytes_hashed, digests_checked, overflow_digests, seed_writes);
      if (mismatch_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("%0d mismatches", mismatch_count);
         $display("Verification failed");
      end
      $finish;
   end

endmodule
